// ===== rtl/otpa_pkg.sv =====
// Shared types, command codes and helper functions for the fp32 outer-product
// tile accumulator. Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps

package otpa_pkg;

  localparam int ROWS_DEFAULT = 8;
  localparam int COLS_DEFAULT = 12;

  localparam int ROW_TAG_W = 4;
  localparam int COL_W     = 4;

  localparam logic [1:0] CMD_PRELOAD = 2'd0;
  localparam logic [1:0] CMD_LOAD_A  = 2'd1;
  localparam logic [1:0] CMD_APPLY   = 2'd2;
  localparam logic [1:0] CMD_DRAIN   = 2'd3;

  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS    = 32'h7F80_0000;

  // Control bundle that the sequencer drives into every cell of the chain.
  typedef struct packed {
    logic                 load;
    logic                 shift;
    logic                 acc_we;
    logic                 a_we;
    logic [ROW_TAG_W-1:0] wr_row;
    logic [COL_W-1:0]     col;
  } cell_ctrl_t;

  // Index of the highest set bit, zero for a zero word.
  function automatic logic [5:0] top_bit64(input logic [63:0] v);
    logic [5:0] t;
    t = 6'd0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) t = 6'(i);
    end
    return t;
  endfunction

endpackage

// ===== rtl/otpa_cell.sv =====
// One row cell of the tile: holds the A element and the accumulators of its row,
// plus one stage of the operand shift chain. Depends on otpa_pkg.
`timescale 1ns / 1ps

module otpa_cell #(
  parameter int COLS = otpa_pkg::COLS_DEFAULT,
  parameter int IDX  = 0
) (
  input  logic                clk,
  input  otpa_pkg::cell_ctrl_t ctrl,
  input  logic [31:0]         wr_data,
  input  logic [31:0]         in_a,
  input  logic [31:0]         in_c,
  output logic [31:0]         out_a,
  output logic [31:0]         out_c
);

  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

  logic [31:0] a_reg;
  logic [31:0] acc [COLS];
  logic [31:0] sh_a;
  logic [31:0] sh_c;
  logic        row_hit;

  assign row_hit = (ctrl.wr_row == otpa_pkg::ROW_TAG_W'(IDX));

  always_ff @(posedge clk) begin
    if (ctrl.a_we && row_hit) a_reg <= wr_data;
    if (ctrl.acc_we && row_hit) acc[ctrl.col[CW-1:0]] <= wr_data;
    // A load captures this row into the chain; shifts then move it toward row 0.
    if (ctrl.load) begin
      sh_a <= a_reg;
      sh_c <= acc[ctrl.col[CW-1:0]];
    end else if (ctrl.shift) begin
      sh_a <= in_a;
      sh_c <= in_c;
    end
  end

  assign out_a = sh_a;
  assign out_c = sh_c;

endmodule

// ===== rtl/otpa_fma.sv =====
// Seven-stage pipelined binary32 fused multiply-add, round to nearest even,
// subnormals kept, one issue per cycle. Depends on otpa_pkg.
`timescale 1ns / 1ps

module otpa_fma (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [otpa_pkg::ROW_TAG_W-1:0] in_tag,
  input  logic [31:0]                    a,
  input  logic [31:0]                    b,
  input  logic [31:0]                    c,
  output logic                           out_valid,
  output logic [otpa_pkg::ROW_TAG_W-1:0] out_tag,
  output logic [31:0]                    result,
  output logic                           busy
);

  localparam int TW = otpa_pkg::ROW_TAG_W;

  // Stage 1: classify, specials, significand product.
  logic [7:0]  ea, eb, ec;
  logic        an, bn, cn, ai, bi, ci, az, bz, cz, sp, sc;
  logic        spec;
  logic [31:0] sval;
  logic [23:0] sa, sb, sq;
  logic signed [11:0] xa, xb, xq;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    ec = c[30:23];
    an = (ea == 8'hFF) && (a[22:0] != 23'd0);
    bn = (eb == 8'hFF) && (b[22:0] != 23'd0);
    cn = (ec == 8'hFF) && (c[22:0] != 23'd0);
    ai = (ea == 8'hFF) && (a[22:0] == 23'd0);
    bi = (eb == 8'hFF) && (b[22:0] == 23'd0);
    ci = (ec == 8'hFF) && (c[22:0] == 23'd0);
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    cz = (c[30:0] == 31'd0);
    sp = a[31] ^ b[31];
    sc = c[31];
    spec = 1'b1;
    sval = 32'd0;
    if (an) sval = a | otpa_pkg::QUIET_BIT;
    else if (bn) sval = b | otpa_pkg::QUIET_BIT;
    else if (cn) sval = c | otpa_pkg::QUIET_BIT;
    else if ((ai && bz) || (bi && az)) sval = otpa_pkg::DEFAULT_NAN;
    else if (ai || bi) begin
      if (ci && (sc != sp)) sval = otpa_pkg::DEFAULT_NAN;
      else sval = {sp, 31'd0} | otpa_pkg::INF_BITS;
    end else if (ci) sval = c;
    else if (az || bz) begin
      if (cz) sval = (sp == sc) ? {sp, 31'd0} : 32'd0;
      else sval = c;
    end else spec = 1'b0;
    sa = {(ea != 8'd0), a[22:0]};
    sb = {(eb != 8'd0), b[22:0]};
    sq = {(ec != 8'd0), c[22:0]};
    xa = (ea != 8'd0) ? ($signed({4'd0, ea}) - 12'sd150) : -12'sd149;
    xb = (eb != 8'd0) ? ($signed({4'd0, eb}) - 12'sd150) : -12'sd149;
    xq = (ec != 8'd0) ? ($signed({4'd0, ec}) - 12'sd150) : -12'sd149;
  end

  logic v1, v2, v3, v4, v5, v6, v7;
  logic [TW-1:0] t1, t2, t3, t4, t5, t6, t7;
  logic spec1, spec2, spec3, spec4, spec5, spec6;
  logic [31:0] sv1, sv2, sv3, sv4, sv5, sv6;
  logic sp1, sp2, sp3, sc1, sc2, sc3, cz1, cz2, cz3;
  logic [47:0] p1, p2;
  logic [23:0] q1, q2;
  logic signed [11:0] pe1, pe2, qe1, qe2;
  logic [5:0] tp2, tq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    t1 <= in_tag; spec1 <= spec; sv1 <= sval;
    p1 <= sa * sb; pe1 <= xa + xb; q1 <= sq; qe1 <= xq;
    sp1 <= sp; sc1 <= sc; cz1 <= cz;
  end

  // Stage 2: leading-one positions.
  always_ff @(posedge clk) begin
    t2 <= t1; spec2 <= spec1; sv2 <= sv1;
    p2 <= p1; pe2 <= pe1; q2 <= q1; qe2 <= qe1;
    sp2 <= sp1; sc2 <= sc1; cz2 <= cz1;
    tp2 <= otpa_pkg::top_bit64({16'd0, p1});
    tq2 <= otpa_pkg::top_bit64({40'd0, q1});
  end

  // Stage 3: normalize both terms to bit 61.
  logic [5:0]  np, nq;
  logic [63:0] pn3, qn3;
  logic signed [11:0] pe3, qe3;
  assign np = 6'd61 - tp2;
  assign nq = 6'd61 - tq2;

  always_ff @(posedge clk) begin
    t3 <= t2; spec3 <= spec2; sv3 <= sv2;
    sp3 <= sp2; sc3 <= sc2; cz3 <= cz2;
    pn3 <= {16'd0, p2} << np;
    qn3 <= {40'd0, q2} << nq;
    pe3 <= pe2 - $signed({6'd0, np});
    qe3 <= qe2 - $signed({6'd0, nq});
  end

  // Stage 4: order by magnitude and align the smaller term with sticky.
  logic        pbig;
  logic [63:0] bg, sm, sm_al;
  logic signed [11:0] bge, dd;
  logic        bgs;
  logic        eff_sub;

  always_comb begin
    pbig = (pe3 > qe3) || ((pe3 == qe3) && (pn3 >= qn3));
    if (cz3) begin
      bg = pn3; bge = pe3; bgs = sp3; sm = 64'd0; dd = 12'sd0; eff_sub = 1'b0;
    end else if (pbig) begin
      bg = pn3; bge = pe3; bgs = sp3; sm = qn3; dd = pe3 - qe3; eff_sub = (sp3 != sc3);
    end else begin
      bg = qn3; bge = qe3; bgs = sc3; sm = pn3; dd = qe3 - pe3; eff_sub = (sp3 != sc3);
    end
    if (dd >= 12'sd64) sm_al = {63'd0, (sm != 64'd0)};
    else if (dd > 12'sd0)
      sm_al = (sm >> dd[5:0]) | {63'd0, ((sm & ((64'd1 << dd[5:0]) - 64'd1)) != 64'd0)};
    else sm_al = sm;
  end

  logic [63:0] bg4, sm4, sum5, sum6;
  logic signed [11:0] bge4, bge5, lsb6, sh6;
  logic bgs4, bgs5, bgs6, sub4, z5, z6;

  always_ff @(posedge clk) begin
    t4 <= t3; spec4 <= spec3; sv4 <= sv3;
    bg4 <= bg; sm4 <= sm_al; bge4 <= bge; bgs4 <= bgs; sub4 <= eff_sub;
  end

  // Stage 5: add or subtract; an exact cancellation gives +0.
  logic [63:0] sum;
  assign sum = sub4 ? (bg4 - sm4) : (bg4 + sm4);

  always_ff @(posedge clk) begin
    t5 <= t4; spec5 <= spec4; sv5 <= sv4;
    sum5 <= sum; bge5 <= bge4; bgs5 <= bgs4;
    z5 <= sub4 && (sum == 64'd0);
  end

  // Stage 6: find the result exponent, clamped at the subnormal floor.
  logic [5:0] m6;
  logic signed [11:0] lsb;
  always_comb begin
    m6 = otpa_pkg::top_bit64(sum5);
    lsb = $signed({6'd0, m6}) + bge5 - 12'sd23;
    if (lsb < -12'sd149) lsb = -12'sd149;
  end

  always_ff @(posedge clk) begin
    t6 <= t5; spec6 <= spec5; sv6 <= sv5;
    sum6 <= sum5; bgs6 <= bgs5; z6 <= z5;
    lsb6 <= lsb;
    sh6 <= lsb - bge5;
  end

  // Stage 7: round to nearest even and pack.
  logic [63:0] qv, rem, half;
  logic signed [11:0] nsh, be;
  logic [32:0] bits;
  logic [31:0] packed_res;

  always_comb begin
    nsh = -sh6;
    rem = 64'd0;
    half = 64'd0;
    if (sh6 <= 12'sd0) qv = sum6 << nsh[4:0];
    else if (sh6 < 12'sd64) begin
      qv = sum6 >> sh6[5:0];
      rem = sum6 & ((64'd1 << sh6[5:0]) - 64'd1);
      half = 64'd1 << (sh6[5:0] - 6'd1);
      if ((rem > half) || ((rem == half) && qv[0])) qv = qv + 64'd1;
    end else qv = 64'd0;
    be = lsb6 + 12'sd149;
    bits = {2'd0, be[7:0], 23'd0} + qv[32:0];
    if ((be >= 12'sd255) || (bits >= {1'b0, otpa_pkg::INF_BITS}))
      packed_res = {bgs6, 31'd0} | otpa_pkg::INF_BITS;
    else packed_res = {bgs6, bits[30:0]};
  end

  always_ff @(posedge clk) begin
    t7 <= t6;
    if (spec6) result <= sv6;
    else if (z6) result <= 32'd0;
    else result <= packed_res;
  end

  assign out_valid = v7;
  assign out_tag = t7;
  assign busy = v1 | v2 | v3 | v4 | v5 | v6 | v7;

endmodule

// ===== rtl/fp32_outer_product_tile_accumulate.sv =====
// Top level of the fp32 outer-product tile accumulator: sequencer, chain of row
// cells and the shared FMA pipeline. Depends on otpa_pkg, otpa_cell, otpa_fma.
//
// Usage: commands arrive on the input channel (in_valid/in_ready) with fields
// cmd, row, col and value. A preload writes one accumulator and a load writes
// one A element. An apply captures the addressed column of all row cells into
// the shift chain, then shifts one row per cycle into the single FMA unit; the
// results pass through its seven pipeline stages and are written back before
// the block returns to idle. A drain moves the column out of the chain as ROWS
// result transfers on the output channel (out_valid/out_ready), row 0 first,
// with last on the final row. The output register holds a result while the
// receiver stalls and the chain waits with it; once the last result sits in the
// output register the block takes new commands. Commands with an out-of-range
// row or column are accepted and dropped, but a load ignores the column. Reset
// clears the sequencer, the FMA valid bits and output valid only; the tile
// contents are undefined until written.
`timescale 1ns / 1ps

module fp32_outer_product_tile_accumulate #(
  parameter int ROWS = otpa_pkg::ROWS_DEFAULT,
  parameter int COLS = otpa_pkg::COLS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [2:0]  row,
  input  logic [3:0]  col,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_row,
  output logic [3:0]  out_col,
  output logic [31:0] result,
  output logic        last
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TW = otpa_pkg::ROW_TAG_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]    state;
  logic [RW-1:0] rcnt;
  logic [31:0]   b_reg;
  logic [3:0]    col_q;
  logic          rcnt_end, col_ok, row_ok, accept, take;

  otpa_pkg::cell_ctrl_t ctrl;
  logic [31:0] wr_data;
  logic [31:0] ch_a [ROWS+1];
  logic [31:0] ch_c [ROWS+1];

  logic          wb_valid, fma_busy;
  logic [TW-1:0] wb_tag;
  logic [31:0]   wb_result;

  assign rcnt_end = (rcnt == RW'(ROWS - 1));
  assign col_ok = ({1'b0, col} < 5'(COLS));
  assign row_ok = ({2'b0, row} < 5'(ROWS));
  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign take = !out_valid || out_ready;

  always_comb begin
    ctrl = '0;
    wr_data = value;
    if (state == ST_IDLE) begin
      ctrl.col = col;
      ctrl.wr_row = TW'(row);
      if (accept) begin
        case (cmd)
          otpa_pkg::CMD_PRELOAD: ctrl.acc_we = row_ok && col_ok;
          otpa_pkg::CMD_LOAD_A:  ctrl.a_we = row_ok;
          otpa_pkg::CMD_APPLY:   ctrl.load = col_ok;
          otpa_pkg::CMD_DRAIN:   ctrl.load = col_ok;
          default:               ctrl.load = 1'b0;
        endcase
      end
    end else begin
      ctrl.col = col_q;
      ctrl.wr_row = wb_tag;
      wr_data = wb_result;
      ctrl.acc_we = wb_valid;
      ctrl.shift = (state == ST_APPLY) || ((state == ST_DRAIN) && take);
    end
  end

  assign ch_a[ROWS] = 32'd0;
  assign ch_c[ROWS] = 32'd0;

  for (genvar r = 0; r < ROWS; r++) begin : g_cell
    otpa_cell #(
      .COLS(COLS),
      .IDX (r)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .wr_data(wr_data),
      .in_a   (ch_a[r+1]),
      .in_c   (ch_c[r+1]),
      .out_a  (ch_a[r]),
      .out_c  (ch_c[r])
    );
  end

  otpa_fma u_fma (
    .clk      (clk),
    .rst      (rst),
    .in_valid (state == ST_APPLY),
    .in_tag   (TW'(rcnt)),
    .a        (ch_a[0]),
    .b        (b_reg),
    .c        (ch_c[0]),
    .out_valid(wb_valid),
    .out_tag  (wb_tag),
    .result   (wb_result),
    .busy     (fma_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rcnt <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && col_ok) begin
            rcnt <= '0;
            if (cmd == otpa_pkg::CMD_APPLY) state <= ST_APPLY;
            else if (cmd == otpa_pkg::CMD_DRAIN) state <= ST_DRAIN;
          end
        end
        ST_APPLY: begin
          if (rcnt_end) state <= ST_FLUSH;
          else rcnt <= rcnt + RW'(1);
        end
        ST_FLUSH: begin
          if (!fma_busy) state <= ST_IDLE;
        end
        ST_DRAIN: begin
          if (take) begin
            if (rcnt_end) state <= ST_IDLE;
            else rcnt <= rcnt + RW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
      if ((state == ST_DRAIN) && take) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_reg <= value;
      col_q <= col;
    end
    if ((state == ST_DRAIN) && take) begin
      out_row <= 3'(rcnt);
      out_col <= col_q;
      result <= ch_c[0];
      last <= rcnt_end;
    end
  end

endmodule

// ===== rtl/otpa_checker.sv =====
// Port-level assertions for the tile accumulator, attached by bind.
// Depends on fp32_outer_product_tile_accumulate.
`timescale 1ns / 1ps

module otpa_checker #(
  parameter int ROWS = otpa_pkg::ROWS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_row,
  input logic [3:0]  out_col,
  input logic [31:0] result,
  input logic        last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result) && $stable(out_row))
    else $error("stalled result changed");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> out_row == 3'(ROWS - 1))
    else $error("last mark on wrong row");

  a_next_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && out_row == 3'($past(out_row) + 3'd1) && $stable(out_col))
    else $error("drain rows not consecutive");

  a_busy_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("command taken during a drain");

endmodule

bind fp32_outer_product_tile_accumulate otpa_checker #(.ROWS(ROWS)) u_otpa_checker (.*);

// ===== bench/tile_acc_checker.sv =====
// Watches both channels of the tile accumulator, keeps its own copy of the tile and
// the A column, and checks every drained result. Depends on otpa_pkg for the command codes.
`timescale 1ns / 1ps

module tile_acc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [2:0]  row,
  input  logic [3:0]  col,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_row,
  input  logic [3:0]  out_col,
  input  logic [31:0] result,
  input  logic        last,
  output int          errors,
  output int          pending
);
  localparam int NROW = 8;
  localparam int NCOL = 12;

  typedef struct packed {
    logic [2:0]  r;
    logic [3:0]  c;
    logic [31:0] v;
    logic        l;
  } drain_word_t;

  logic [31:0] tile [NCOL][NROW];
  logic [31:0] a_col [NROW];
  drain_word_t drain_q [$];

  function automatic int msb_of(logic [63:0] v);
    int t;
    t = 0;
    for (int i = 1; i < 64; i++) if (v[i]) t = i;
    return t;
  endfunction

  function automatic logic [31:0] pack_rne(logic s, logic [63:0] m, int e);
    int hi, lsb, sh, be;
    logic [63:0] q, r, half, bits;
    hi = msb_of(m);
    lsb = hi + e - 23;
    if (lsb < -149) lsb = -149;
    sh = lsb - e;
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh < 64) begin
      half = 64'd1 << (sh - 1);
      q = m >> sh;
      r = m & ((64'd1 << sh) - 64'd1);
      if (r > half || (r == half && q[0])) q = q + 64'd1;
    end else begin
      q = 64'd0;
      if (sh == 64 && m > (64'd1 << 63)) q = 64'd1;
    end
    be = lsb + 149;
    if (be >= 255) return {s, 31'h7F80_0000};
    bits = (64'(be) << 23) + q;
    if (bits >= 64'h7F80_0000) return {s, 31'h7F80_0000};
    return {s, bits[30:0]};
  endfunction

  function automatic void split(logic [31:0] x, output logic [63:0] m, output int e);
    m = (x[30:23] != 0) ? {40'd0, 1'b1, x[22:0]} : {41'd0, x[22:0]};
    e = (x[30:23] != 0) ? int'(x[30:23]) - 150 : -149;
  endfunction

  function automatic void to_bit61(inout logic [63:0] m, inout int e);
    int s;
    s = 61 - msb_of(m);
    m = m << s;
    e = e - s;
  endfunction

  // Single-rounding a*b+c, round to nearest even, subnormals kept.
  function automatic logic [31:0] fma32(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic an, bn, cn, ai, bi, ci, az, bz, cz, sp, sc, bigs;
    logic [63:0] sa, sb, p, q, big, lil, lost;
    int xa, xb, pe, qe, bige, d;
    an = a[30:23] == 8'hFF && a[22:0] != 0;
    bn = b[30:23] == 8'hFF && b[22:0] != 0;
    cn = c[30:23] == 8'hFF && c[22:0] != 0;
    ai = a[30:23] == 8'hFF && a[22:0] == 0;
    bi = b[30:23] == 8'hFF && b[22:0] == 0;
    ci = c[30:23] == 8'hFF && c[22:0] == 0;
    az = a[30:0] == 0;
    bz = b[30:0] == 0;
    cz = c[30:0] == 0;
    sp = a[31] ^ b[31];
    sc = c[31];
    if (an) return a | 32'h0040_0000;
    if (bn) return b | 32'h0040_0000;
    if (cn) return c | 32'h0040_0000;
    if ((ai && bz) || (bi && az)) return 32'h7FC0_0000;
    if (ai || bi) begin
      if (ci && sc != sp) return 32'h7FC0_0000;
      return {sp, 31'h7F80_0000};
    end
    if (ci) return c;
    if (az || bz) begin
      if (cz) return (sp == sc) ? {sp, 31'd0} : 32'd0;
      return c;
    end
    split(a, sa, xa);
    split(b, sb, xb);
    p = sa * sb;
    pe = xa + xb;
    to_bit61(p, pe);
    if (cz) return pack_rne(sp, p, pe);
    split(c, q, qe);
    to_bit61(q, qe);
    if (pe > qe || (pe == qe && p >= q)) begin
      big = p; bige = pe; bigs = sp; lil = q; d = pe - qe;
    end else begin
      big = q; bige = qe; bigs = sc; lil = p; d = qe - pe;
    end
    if (d >= 64) begin
      lil = (lil != 0) ? 64'd1 : 64'd0;
    end else if (d > 0) begin
      lost = lil & ((64'd1 << d) - 64'd1);
      lil = (lil >> d) | ((lost != 0) ? 64'd1 : 64'd0);
    end
    if (sp == sc) begin
      big = big + lil;
    end else begin
      big = big - lil;
      if (big == 0) return 32'd0;
    end
    return pack_rne(bigs, big, bige);
  endfunction

  assign pending = drain_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    drain_word_t w;
    if (!rst) begin
      if (in_valid && in_ready) begin
        case (cmd)
          otpa_pkg::CMD_PRELOAD: if (col < NCOL) tile[col][row] = value;
          otpa_pkg::CMD_LOAD_A:  a_col[row] = value;
          otpa_pkg::CMD_APPLY: begin
            if (col < NCOL)
              for (int r = 0; r < NROW; r++) tile[col][r] = fma32(a_col[r], value, tile[col][r]);
          end
          default: begin
            if (col < NCOL)
              for (int r = 0; r < NROW; r++)
                drain_q.push_back('{3'(r), col, tile[col][r], r == NROW - 1});
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (drain_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result row %0d col %0d value %h last %b",
                     out_row, out_col, result, last);
        end else begin
          w = drain_q.pop_front();
          if (out_row !== w.r || out_col !== w.c || result !== w.v || last !== w.l) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp row %0d col %0d %h last %b, got row %0d col %0d %h last %b",
                       w.r, w.c, w.v, w.l, out_row, out_col, result, last);
          end
        end
      end
    end
  end
endmodule

// ===== bench/tb_fp32_outer_product_tile_accumulate.sv =====
// Stimulus and verdict for the fp32 outer-product tile accumulator. Depends on otpa_pkg,
// the block under test and tile_acc_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_fp32_outer_product_tile_accumulate;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = '0;
  logic [2:0]  row = '0;
  logic [3:0]  col = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_row;
  logic [3:0]  out_col;
  logic [31:0] result;
  logic        last;
  int          errors, pending;
  int          idle_cycles = 0;

  // Written-row masks, so that nothing unwritten is ever read back or applied.
  logic [7:0]  col_ok [12];
  logic [7:0]  a_ok = '0;

  always #5 clk = ~clk;

  fp32_outer_product_tile_accumulate i_dut (
    .clk, .rst, .in_valid, .in_ready, .cmd, .row, .col, .value,
    .out_valid, .out_ready, .out_row, .out_col, .result, .last
  );

  tile_acc_checker i_chk (
    .clk, .rst, .in_valid, .in_ready, .cmd, .row, .col, .value,
    .out_valid, .out_ready, .out_row, .out_col, .result, .last,
    .errors, .pending
  );

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] specials [12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
      32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hFF81_2345, 32'h7F7F_FFFF,
      32'h0000_0001, 32'h0080_0000, 32'h3F80_0000, 32'hBF80_0000};
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return x;
      2:    return specials[$urandom_range(0, 11)];
      3:    return {x[31], 8'h00, x[22:0]};
      default: return {x[31], 8'($urandom_range(118, 136)), x[22:0]};
    endcase
  endfunction

  // Receiver: random stalls, mostly short, now and then a long one, and ready stretches.
  always @(negedge clk) begin
    if (idle_cycles == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        idle_cycles = gap_len() + 1;
      end else begin
        out_ready <= 1'b1;
        idle_cycles = $urandom_range(1, 12);
      end
    end else begin
      idle_cycles--;
    end
  end

  task automatic transfer(logic [1:0] c, logic [2:0] r, logic [3:0] k, logic [31:0] v);
    int g;
    @(negedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    row <= r;
    col <= k;
    value <= v;
    do @(posedge clk); while (!in_ready);
    if (c == otpa_pkg::CMD_PRELOAD && k < 12) col_ok[k][r] = 1'b1;
    if (c == otpa_pkg::CMD_LOAD_A) a_ok[r] = 1'b1;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  int watchdog = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("[fp32_outer_product_tile_accumulate] ERROR");
      $finish;
    end
  end

  initial begin
    int sent, k, steps;
    logic [1:0] op;
    logic [31:0] a_dir [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                               32'h7F80_0001, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0000};
    logic [31:0] c_dir [8] = '{32'h7F80_0000, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                               32'h3F80_0000, 32'h7F7F_FFFF, 32'h8000_0001, 32'hBF80_0000};
    for (int i = 0; i < 12; i++) col_ok[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: operand extremes, NaN and infinity handling, exact cancellation, overflow,
    // and the out-of-range column cases.
    for (int r = 0; r < 8; r++) transfer(otpa_pkg::CMD_LOAD_A, 3'(r), 4'd0, a_dir[r]);
    for (int r = 0; r < 8; r++) transfer(otpa_pkg::CMD_PRELOAD, 3'(r), 4'd11, c_dir[r]);
    transfer(otpa_pkg::CMD_PRELOAD, 3'd0, 4'd15, 32'hFFFF_FFFF);
    transfer(otpa_pkg::CMD_APPLY, 3'd0, 4'd11, 32'hBF80_0000);
    transfer(otpa_pkg::CMD_APPLY, 3'd7, 4'd11, 32'h7F7F_FFFF);
    transfer(otpa_pkg::CMD_APPLY, 3'd0, 4'd12, 32'h3F80_0000);
    transfer(otpa_pkg::CMD_DRAIN, 3'd0, 4'd11, 32'd0);
    transfer(otpa_pkg::CMD_DRAIN, 3'd0, 4'd15, 32'd0);
    transfer(otpa_pkg::CMD_DRAIN, 3'd7, 4'd11, 32'hFFFF_FFFF);

    sent = 0;
    while (sent < 230) begin
      if (sent > 100 && sent < 130) begin
        // The sender goes quiet until every drained row has come back.
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
      end
      if ($urandom_range(0, 99) < 65) begin
        // One tile column through preload, a few rank-1 steps and a drain.
        k = $urandom_range(0, 11);
        for (int r = 0; r < 8; r++)
          if (col_ok[k] != 8'hFF || $urandom_range(0, 1)) begin
            transfer(otpa_pkg::CMD_PRELOAD, 3'(r), 4'(k), rand_float());
            sent++;
          end
        steps = $urandom_range(1, 3);
        for (int s = 0; s < steps; s++) begin
          for (int r = 0; r < 8; r++)
            if (a_ok != 8'hFF || $urandom_range(0, 1)) begin
              transfer(otpa_pkg::CMD_LOAD_A, 3'(r), 4'($urandom_range(0, 15)), rand_float());
              sent++;
            end
          transfer(otpa_pkg::CMD_APPLY, 3'($urandom), 4'(k), rand_float());
          sent++;
        end
        transfer(otpa_pkg::CMD_DRAIN, 3'($urandom), 4'(k), $urandom);
        sent++;
      end else begin
        op = 2'($urandom_range(0, 3));
        k = $urandom_range(0, 15);
        if ((op == otpa_pkg::CMD_APPLY &&
             (a_ok != 8'hFF || (k < 12 && col_ok[k] != 8'hFF))) ||
            (op == otpa_pkg::CMD_DRAIN && k < 12 && col_ok[k] != 8'hFF))
          k = $urandom_range(12, 15);
        transfer(op, 3'($urandom), 4'(k), rand_float());
        sent++;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[fp32_outer_product_tile_accumulate] OK");
    end else begin
      $display("[fp32_outer_product_tile_accumulate] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/otpa_pkg.sv
rtl/otpa_cell.sv
rtl/otpa_fma.sv
rtl/fp32_outer_product_tile_accumulate.sv
rtl/otpa_checker.sv
bench/tile_acc_checker.sv
bench/tb_fp32_outer_product_tile_accumulate.sv
